@@ hw/rtl/rle_pixel_decoder_assert.svh @@
// Assertion macros for the run-length pixel decoder.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef RLE_PIXEL_DECODER_ASSERT_SVH
`define RLE_PIXEL_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property, checked on every rising clock edge outside reset.
`define RLEPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication.
`define RLEPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RLEPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLEPD_ASSERT(lbl, prop, msg)
`define RLEPD_ASSERT_IMP(lbl, ante, cons, msg)
`define RLEPD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/rlepd_pkg.sv @@
package rlepd_pkg;

  // Width of the decoded pixel counter and of the compared pixel total.
  localparam int unsigned PixCountW = 24;
  localparam int unsigned TotalW    = 24;
  localparam int unsigned PixW      = 32;
  localparam int unsigned CountW    = 7;
  localparam int unsigned PbW       = 3;

  // Register map (index = paddr[2]).
  localparam int unsigned ApbAddrW  = 3;
  localparam logic        RegPixelBytes  = 1'b0;
  localparam logic        RegTotalPixels = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [PbW-1:0]    PixelBytesRst  = 3'd3;
  localparam logic [TotalW-1:0] TotalPixelsRst = 24'd16384;

  // Pixel sizes and header decoding.
  localparam logic [PbW-1:0] RgbBytes   = 3'd3;
  localparam logic [PbW-1:0] RgbaBytes  = 3'd4;
  localparam int unsigned    HdrRunBit  = 7;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } rlepd_phase_e;

  typedef struct packed {
    logic [PbW-1:0]    pixel_bytes;
    logic [TotalW-1:0] total_pixels;
  } rlepd_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [PixW-1:0]   pixel_value;
    logic [CountW-1:0] repeat_count;
    logic              end_of_image;
    logic              overrun;
  } rlepd_res_t;

endpackage

@@ hw/rtl/rle_pixel_decoder.sv @@
// Channel   Handshake                Payload
// input     in_valid_i / in_ready_o  stream_byte_i
// output    out_valid_o / out_ready_i pixel_value_o, repeat_count_o, end_of_image_o, overrun_o
// config    psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// One byte per cycle is taken unless a held result stalls the input; a byte flows input
// register -> decode -> result register, which presents a pixel result once its last byte is decoded.
// Reset clears the decode state; decoding restarts at a header byte.
// When the result register is held, the input register holds too and input ready
// stays high only while the input register is empty.
`include "rle_pixel_decoder_assert.svh"

module rle_pixel_decoder import rlepd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          stream_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     pixel_value_o,
  output logic [CountW-1:0]   repeat_count_o,
  output logic                end_of_image_o,
  output logic                overrun_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  rlepd_cfg_t cfg;
  rlepd_res_t res;
  logic       finished;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  rlepd_res_t out_q;
  logic       step;

  rlepd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A held byte is decoded when the result register is free or being drained.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  rlepd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .cfg_i      (cfg),
    .res_o      (res),
    .finished_o (finished)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= stream_byte_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_q.pixel_value;
  assign repeat_count_o = out_q.repeat_count;
  assign end_of_image_o = out_q.end_of_image;
  assign overrun_o      = out_q.overrun;

  // A pixel is never written zero times.
  `RLEPD_ASSERT_IMP(a_count_nonzero, out_valid_q, out_q.repeat_count != '0, "zero repeat count")
  // The final pixel of an image leaves the decoder finished.
  `RLEPD_ASSERT_IMP(a_eoi_finished, out_valid_q && out_q.end_of_image, finished, "eoi not finished")
  // A byte waiting behind a stalled result is kept.
  `RLEPD_ASSERT_NXT(a_in_hold, in_valid_q && out_valid_q && !out_ready_i, in_valid_q, "byte lost")

endmodule

@@ hw/rtl/rlepd_regs.sv @@
module rlepd_regs import rlepd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rlepd_cfg_t          cfg_o
);

  logic [PbW-1:0]    pixel_bytes_q;
  logic [TotalW-1:0] total_pixels_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_bytes_q  <= PixelBytesRst;
      total_pixels_q <= TotalPixelsRst;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegPixelBytes:  pixel_bytes_q  <= pwdata[PbW-1:0];
        RegTotalPixels: total_pixels_q <= pwdata[TotalW-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr[2])
      RegPixelBytes:  prdata = 32'(pixel_bytes_q);
      RegTotalPixels: prdata = 32'(total_pixels_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.pixel_bytes  = pixel_bytes_q;
  assign cfg_o.total_pixels = total_pixels_q;

endmodule

@@ hw/rtl/rlepd_core.sv @@
module rlepd_core import rlepd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  rlepd_cfg_t cfg_i,
  output rlepd_res_t res_o,
  output logic       finished_o
);

  rlepd_phase_e         phase_q, phase_d;
  logic [CountW-1:0]    run_left_q, run_left_d;
  logic [1:0]           bip_q, bip_d;
  logic [PixW-1:0]      gather_q, gather_d;
  logic [PixCountW-1:0] done_q, done_d;
  logic                 finished_q, finished_d;

  logic [PixCountW-1:0] total_c;
  logic [PixCountW-1:0] remaining;
  logic [PixCountW-1:0] done_new;
  logic [PixW-1:0]      gather_new;
  logic [PbW-1:0]       pb;
  logic [PbW-1:0]       got;
  logic [CountW-1:0]    hdr_len;
  logic [CountW-1:0]    count;
  logic                 halted;
  logic                 gathering;
  logic                 is_repeat;
  logic                 pix_last;
  logic                 over;
  logic                 eoi;
  logic                 live;

  // Shared decode of the current byte against the state.
  always_comb begin
    total_c    = PixCountW'(cfg_i.total_pixels);
    halted     = finished_q || (done_q >= total_c);
    live       = step_i && !halted;
    gathering  = (phase_q == PH_REPEAT) || (phase_q == PH_LITERAL);
    is_repeat  = (phase_q == PH_REPEAT);
    hdr_len    = byte_i[CountW-1:0];
    pb         = (cfg_i.pixel_bytes > RgbBytes) ? RgbaBytes : RgbBytes;
    got        = {1'b0, bip_q} + PbW'(1);
    pix_last   = (got >= pb);
    gather_new = ((bip_q == 2'd0) ? '0 : gather_q) | (PixW'(byte_i) << {bip_q, 3'b000});
    remaining  = total_c - done_q;
    over       = PixCountW'(run_left_q) > remaining;
    if (is_repeat) begin
      count = over ? remaining[CountW-1:0] : run_left_q;
    end else begin
      count = CountW'(1);
    end
    done_new = done_q + PixCountW'(count);
    eoi      = (done_new >= total_c);
  end

  // Phase transitions.
  always_comb begin
    phase_d = phase_q;
    if (live) begin
      unique case (phase_q)
        PH_REPEAT: begin
          if (pix_last) phase_d = PH_HEADER;
        end
        PH_LITERAL: begin
          if (pix_last && (run_left_q == CountW'(1))) phase_d = PH_HEADER;
        end
        default: begin
          if (hdr_len == '0) begin
            phase_d = PH_HEADER;
          end else if (byte_i[HdrRunBit]) begin
            phase_d = PH_REPEAT;
          end else begin
            phase_d = PH_LITERAL;
          end
        end
      endcase
    end
  end

  // Datapath state and result.
  always_comb begin
    run_left_d = run_left_q;
    bip_d      = bip_q;
    gather_d   = gather_q;
    done_d     = done_q;
    finished_d = finished_q;
    res_o.valid        = 1'b0;
    res_o.pixel_value  = (pb == RgbaBytes) ? gather_new : {8'h00, gather_new[23:0]};
    res_o.repeat_count = count;
    res_o.end_of_image = eoi;
    res_o.overrun      = over;
    if (live) begin
      if (!gathering) begin
        if (hdr_len != '0) begin
          run_left_d = hdr_len;
          bip_d      = 2'd0;
          gather_d   = '0;
        end
      end else if (!pix_last) begin
        bip_d    = got[1:0];
        gather_d = gather_new;
      end else begin
        bip_d       = 2'd0;
        gather_d    = '0;
        run_left_d  = is_repeat ? '0 : (run_left_q - CountW'(1));
        done_d      = done_new;
        finished_d  = eoi;
        res_o.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      run_left_q <= '0;
      bip_q      <= '0;
      gather_q   <= '0;
      done_q     <= '0;
      finished_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      run_left_q <= run_left_d;
      bip_q      <= bip_d;
      gather_q   <= gather_d;
      done_q     <= done_d;
      finished_q <= finished_d;
    end
  end

  assign finished_o = finished_q;

endmodule
